// ===== rtl/l3d_pkg.sv =====
package l3d_pkg;

  // Fixed widths of the configuration port and of the load index.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned DIM_REG_W  = 6;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERP_MODE = 2'd0,
    REG_LUT_DIM     = 2'd1,
    REG_STEP_SCALE  = 2'd2,
    REG_ALPHA_SCALE = 2'd3
  } reg_idx_e;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Interpolation modes.
  localparam logic MODE_TRILINEAR  = 1'b0;
  localparam logic MODE_TETRAHEDRAL = 1'b1;

  // Register reset values.
  localparam logic [DIM_REG_W-1:0]  RST_LUT_DIM     = 6'd33;
  localparam logic [CFG_DATA_W-1:0] RST_STEP_SCALE  = 32'd2097152;
  localparam logic [CFG_DATA_W-1:0] RST_ALPHA_SCALE = 32'd65536;

  // Corner codes: bit 2 raises red, bit 1 green, bit 0 blue.
  localparam logic [2:0] CORNER_R   = 3'b100;
  localparam logic [2:0] CORNER_G   = 3'b010;
  localparam logic [2:0] CORNER_B   = 3'b001;
  localparam logic [2:0] CORNER_ALL = 3'b111;

endpackage

// ===== rtl/l3d_if.sv =====
// Pixel and load input channel.
interface l3d_pix_if #(
  parameter int unsigned VALUE_BITS = 20
);
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [l3d_pkg::INDEX_W-1:0]       entry_index;
  logic signed [VALUE_BITS-1:0]      entry_r;
  logic signed [VALUE_BITS-1:0]      entry_g;
  logic signed [VALUE_BITS-1:0]      entry_b;
  logic signed [VALUE_BITS-1:0]      pix_r;
  logic signed [VALUE_BITS-1:0]      pix_g;
  logic signed [VALUE_BITS-1:0]      pix_b;
  logic signed [VALUE_BITS-1:0]      pix_a;
  logic                              in_last;

  modport source (
    output valid, func, entry_index, entry_r, entry_g, entry_b,
           pix_r, pix_g, pix_b, pix_a, in_last,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_r, entry_g, entry_b,
           pix_r, pix_g, pix_b, pix_a, in_last,
    output ready
  );
endinterface

// Interpolated pixel output channel.
interface l3d_res_if #(
  parameter int unsigned VALUE_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] out_r;
  logic signed [VALUE_BITS-1:0] out_g;
  logic signed [VALUE_BITS-1:0] out_b;
  logic signed [VALUE_BITS-1:0] out_a;
  logic                         out_last;

  modport source (output valid, out_r, out_g, out_b, out_a, out_last, input ready);
  modport sink (input valid, out_r, out_g, out_b, out_a, out_last, output ready);
endinterface

// Configuration write channel.
interface l3d_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [l3d_pkg::CFG_IDX_W-1:0]     index;
  logic [l3d_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/l3d_ram.sv =====
module l3d_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 35937,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; a read in the same cycle
  // as a write to the same address returns the old content.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lut3d_color_interpolator.sv =====
// Streams pixels through a 3D color lookup table with trilinear or
// tetrahedral interpolation and scales alpha. The block takes one item per
// clock while its spare output slot is empty; a pixel passes through the
// pipeline stages to the output register, and a load writes the table
// at the same stage where pixels read their corners, so a pixel
// sees every load that came before it and none that came after it. The eight
// corners of a pixel's cell are read in one cycle from eight copies of the
// table, each written by every load; each copy has MAX_DIM^3 entries of
// three signed values. The table holds no defined content until loaded and
// needs no clearing after reset. A two-entry output stage keeps the pipeline
// running while a result waits; the input is ready whenever its spare slot
// is empty. Configuration writes are taken in every cycle and must only be
// issued while no pixel is in flight.
module lut3d_color_interpolator #(
  parameter int unsigned MAX_DIM    = 33,
  parameter int unsigned VALUE_BITS = 20,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  l3d_pix_if.sink   pix_i,
  l3d_res_if.source res_o,
  l3d_cfg_if.sink   cfg_i
);

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned GW    = VB + 15;
  localparam int unsigned CW    = (GW > DW + F) ? GW : DW + F;
  localparam int unsigned PA    = VB + 33;
  localparam int unsigned LW    = VB + 1;
  localparam int unsigned TW    = VB + F + 3;
  localparam int unsigned TSW   = VB + F + 5;
  localparam int unsigned SW    = VB + F + 34;
  localparam int unsigned EW    = 3 * VB;
  localparam int unsigned MW    = VB + 31;

  localparam logic signed [TW-1:0] HALF_T = TW'(64'd1 << (F - 1));
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (VB - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
  localparam logic signed [PA-1:0] A_HALF = PA'(32'd32768);

  typedef struct packed {
    logic                  last;
    logic [VB-1:0]         alpha;
    logic [2:0][F-1:0]     fr;
  } side_t;

  typedef struct packed {
    logic          last;
    logic [VB-1:0] a;
    logic [VB-1:0] b;
    logic [VB-1:0] g;
    logic [VB-1:0] r;
  } res_t;

  function automatic logic [VB-1:0] sat_f(input logic signed [SW-1:0] x);
    logic [VB-1:0] r;
    if (x > SAT_HI) begin
      r = {1'b0, {(VB-1){1'b1}}};
    end else if (x < SAT_LO) begin
      r = {1'b1, {(VB-1){1'b0}}};
    end else begin
      r = x[VB-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic                                mode_q;
  logic [l3d_pkg::DIM_REG_W-1:0]       dim_q;
  logic [l3d_pkg::CFG_DATA_W-1:0]      step_q;
  logic [l3d_pkg::CFG_DATA_W-1:0]      ascale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= l3d_pkg::MODE_TRILINEAR;
      dim_q    <= l3d_pkg::RST_LUT_DIM;
      step_q   <= l3d_pkg::RST_STEP_SCALE;
      ascale_q <= l3d_pkg::RST_ALPHA_SCALE;
    end else if (cfg_i.valid) begin
      case (l3d_pkg::reg_idx_e'(cfg_i.index))
        l3d_pkg::REG_INTERP_MODE: mode_q   <= cfg_i.data[0];
        l3d_pkg::REG_LUT_DIM:     dim_q    <= cfg_i.data[l3d_pkg::DIM_REG_W-1:0];
        l3d_pkg::REG_STEP_SCALE:  step_q   <= cfg_i.data;
        l3d_pkg::REG_ALPHA_SCALE: ascale_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Effective grid size and its square, refreshed every cycle.
  logic [DW-1:0]   dim_eff;
  logic [DW-1:0]   d_q;
  logic [2*DW-1:0] d2_q;

  always_comb begin
    if (32'(dim_q) < 32'd2) begin
      dim_eff = DW'(2);
    end else if (32'(dim_q) > MAX_DIM) begin
      dim_eff = DW'(MAX_DIM);
    end else begin
      dim_eff = DW'(dim_q);
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= dim_eff;
    d2_q <= (2*DW)'(dim_eff) * (2*DW)'(dim_eff);
  end

  // Pipeline enable: everything moves unless the spare output slot is full.
  logic   en;
  logic   skid_v_q;
  logic   out_v_q;
  logic [10:1] v_q;

  assign en          = !skid_v_q;
  assign pix_i.ready = en;

  // Stage registers.
  logic                  s1_func_q;
  logic [l3d_pkg::INDEX_W-1:0] s1_idx_q;
  logic [EW-1:0]         s1_entry_q;
  logic signed [VB-1:0]  s1_pix_q [4];
  logic                  s1_last_q;

  logic [4:2]            ld_v_q;
  logic [AW-1:0]         ld_addr_q [2:4];
  logic [EW-1:0]         ld_data_q [2:4];

  logic [GW-1:0]         s2_g_d [3];
  logic [GW-1:0]         s2_g_q [3];
  logic signed [PA-1:0]  s2_a_d;
  logic signed [PA-1:0]  s2_a_q;
  logic                  s2_last_q;

  logic [DW-1:0]         s3_lo_d [3];
  logic [DW-1:0]         s3_hi_d [3];
  logic [DW-1:0]         s3_lo_q [3];
  logic [DW-1:0]         s3_hi_q [3];
  side_t                 side3_d;
  side_t                 side_q [3:10];

  logic [3*DW-1:0]       s4_rl_q, s4_rh_q;
  logic [2*DW-1:0]       s4_gl_q, s4_gh_q;
  logic [DW-1:0]         s4_bl_q, s4_bh_q;
  logic [2:0]            s4_n1_d, s4_n2_d, s4_n1_q, s4_n2_q;
  logic [F-1:0]          s4_tf_d [3];
  logic [F-1:0]          s4_tf_q [3];
  logic [2:0]            s5_n1_q, s5_n2_q;
  logic [F-1:0]          s5_tf_q [3];

  logic [AW-1:0]         raddr [8];
  logic [EW-1:0]         corner [8];

  logic signed [TW-1:0]  s6_p_d [4][3];
  logic signed [TW-1:0]  s6_p_q [4][3];
  logic signed [VB-1:0]  s6_base_d [4][3];
  logic signed [VB-1:0]  s6_base_q [4][3];
  logic signed [TW-1:0]  s6_t_d [3][3];
  logic signed [TW-1:0]  s6_t_q [3][3];
  logic signed [VB-1:0]  s6_v0_d [3];
  logic signed [VB-1:0]  s6_v0_q [3];

  logic signed [LW-1:0]  s7_b_d [4][3];
  logic signed [LW-1:0]  s7_b_q [4][3];
  logic signed [VB-1:0]  t7_d [3];
  logic signed [VB-1:0]  t_q [7:10][3];

  logic signed [TW-1:0]  s8_q_d [2][3];
  logic signed [TW-1:0]  s8_q_q [2][3];
  logic signed [LW-1:0]  s8_base_q [2][3];
  logic signed [LW-1:0]  s9_g_d [2][3];
  logic signed [LW-1:0]  s9_g_q [2][3];
  logic signed [TW-1:0]  s10_r_d [3];
  logic signed [TW-1:0]  s10_r_q [3];
  logic signed [LW-1:0]  s10_base_q [3];

  res_t                  fin;
  res_t                  out_q;
  res_t                  skid_q;

  // Table write from stage 4, the stage where pixels read their corners, so
  // a load only affects pixels that follow it. Indexes beyond the table were
  // dropped at stage 1.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;

  assign ram_we    = en && ld_v_q[4];
  assign ram_waddr = ld_addr_q[4];

  // Stage 2: scale colors to grid coordinates and alpha by its factor.
  always_comb begin
    logic [MW-1:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod = MW'(s1_pix_q[c][VB-2:0]) * MW'(step_q);
      if (!s1_pix_q[c][VB-1] && (s1_pix_q[c] != '0)) begin
        s2_g_d[c] = prod[MW-1:16];
      end else begin
        s2_g_d[c] = '0;
      end
    end
    s2_a_d = PA'(s1_pix_q[3]) * $signed(PA'(ascale_q)) + A_HALF;
  end

  // Stage 3: clamp, split into corners and fractions, finish alpha.
  always_comb begin
    logic [CW-1:0] maxfix;
    logic [CW-1:0] gx;
    logic [CW-1:0] cl;
    maxfix = CW'({d_q - DW'(1), {F{1'b0}}});
    for (int c = 0; c < 3; c++) begin
      gx = CW'(s2_g_q[c]);
      cl = (gx > maxfix) ? maxfix : gx;
      s3_lo_d[c]    = cl[F +: DW];
      side3_d.fr[c] = cl[F-1:0];
      s3_hi_d[c]    = (s3_lo_d[c] < d_q - DW'(1)) ? s3_lo_d[c] + DW'(1) : s3_lo_d[c];
    end
    side3_d.last  = s2_last_q;
    side3_d.alpha = sat_f(SW'(s2_a_q >>> 16));
  end

  // Stage 4: pick the tetrahedron; ties follow the fraction compares below.
  always_comb begin
    logic c0, c1, c2;
    logic [F-1:0] fr, fg, fb;
    fr = side_q[3].fr[0];
    fg = side_q[3].fr[1];
    fb = side_q[3].fr[2];
    c0 = fr >= fg;
    c1 = fg >= fb;
    c2 = fb >= fr;
    if (c0) begin
      if (c1) begin
        s4_n1_d = l3d_pkg::CORNER_R;
        s4_n2_d = l3d_pkg::CORNER_R | l3d_pkg::CORNER_G;
        s4_tf_d[0] = fr; s4_tf_d[1] = fg; s4_tf_d[2] = fb;
      end else if (!c2) begin
        s4_n1_d = l3d_pkg::CORNER_R;
        s4_n2_d = l3d_pkg::CORNER_R | l3d_pkg::CORNER_B;
        s4_tf_d[0] = fr; s4_tf_d[1] = fb; s4_tf_d[2] = fg;
      end else begin
        s4_n1_d = l3d_pkg::CORNER_B;
        s4_n2_d = l3d_pkg::CORNER_R | l3d_pkg::CORNER_B;
        s4_tf_d[0] = fb; s4_tf_d[1] = fr; s4_tf_d[2] = fg;
      end
    end else begin
      if (!c1) begin
        s4_n1_d = l3d_pkg::CORNER_B;
        s4_n2_d = l3d_pkg::CORNER_G | l3d_pkg::CORNER_B;
        s4_tf_d[0] = fb; s4_tf_d[1] = fg; s4_tf_d[2] = fr;
      end else if (!c2) begin
        s4_n1_d = l3d_pkg::CORNER_G;
        s4_n2_d = l3d_pkg::CORNER_R | l3d_pkg::CORNER_G;
        s4_tf_d[0] = fg; s4_tf_d[1] = fr; s4_tf_d[2] = fb;
      end else begin
        s4_n1_d = l3d_pkg::CORNER_G;
        s4_n2_d = l3d_pkg::CORNER_G | l3d_pkg::CORNER_B;
        s4_tf_d[0] = fg; s4_tf_d[1] = fb; s4_tf_d[2] = fr;
      end
    end
  end

  // Corner addresses from the stage 4 partial products.
  always_comb begin
    logic [3*DW:0] sum;
    for (int n = 0; n < 8; n++) begin
      sum = (3*DW+1)'(((n & 4) != 0) ? s4_rh_q : s4_rl_q) +
            (3*DW+1)'(((n & 2) != 0) ? s4_gh_q : s4_gl_q) +
            (3*DW+1)'(((n & 1) != 0) ? s4_bh_q : s4_bl_q);
      raddr[n] = sum[AW-1:0];
    end
  end

  // One table copy per corner.
  for (genvar n = 0; n < 8; n++) begin : g_bank
    l3d_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (ram_waddr),
      .wdata_i (ld_data_q[4]),
      .re_i    (en),
      .raddr_i (raddr[n]),
      .rdata_o (corner[n])
    );
  end

  // Stage 6: blue-axis products and the three tetrahedral products.
  always_comb begin
    logic signed [TW-1:0] ea, eb, ef;
    logic signed [TW-1:0] v0, v1, v2, v3, f1, f2, f3;
    ef = $signed(TW'(side_q[5].fr[2]));
    f1 = $signed(TW'(s5_tf_q[0]));
    f2 = $signed(TW'(s5_tf_q[1]));
    f3 = $signed(TW'(s5_tf_q[2]));
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        ea = TW'($signed(corner[2*k][c*VB +: VB]));
        eb = TW'($signed(corner[2*k+1][c*VB +: VB]));
        s6_p_d[k][c]    = (eb - ea) * ef;
        s6_base_d[k][c] = $signed(corner[2*k][c*VB +: VB]);
      end
      v0 = TW'($signed(corner[0][c*VB +: VB]));
      v1 = TW'($signed(corner[s5_n1_q][c*VB +: VB]));
      v2 = TW'($signed(corner[s5_n2_q][c*VB +: VB]));
      v3 = TW'($signed(corner[l3d_pkg::CORNER_ALL][c*VB +: VB]));
      s6_t_d[0][c] = (v1 - v0) * f1;
      s6_t_d[1][c] = (v2 - v1) * f2;
      s6_t_d[2][c] = (v3 - v2) * f3;
      s6_v0_d[c]   = $signed(corner[0][c*VB +: VB]);
    end
  end

  // Stage 7: round the blue lerps; finish the tetrahedral sum.
  always_comb begin
    logic signed [TW-1:0]  x;
    logic signed [TSW-1:0] acc, rr;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        x = s6_p_q[k][c] + HALF_T;
        s7_b_d[k][c] = LW'(TW'(s6_base_q[k][c]) + (x >>> F));
      end
      acc = TSW'(s6_t_q[0][c]) + TSW'(s6_t_q[1][c]) + TSW'(s6_t_q[2][c]) + TSW'(HALF_T);
      rr  = TSW'(s6_v0_q[c]) + (acc >>> F);
      t7_d[c] = sat_f(SW'(rr));
    end
  end

  // Stages 8 and 9: green-axis lerps.
  always_comb begin
    logic signed [TW-1:0] ef;
    logic signed [TW-1:0] x;
    ef = $signed(TW'(side_q[7].fr[1]));
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 2; j++) begin
        s8_q_d[j][c] = (TW'(s7_b_q[2*j+1][c]) - TW'(s7_b_q[2*j][c])) * ef;
        x = s8_q_q[j][c] + HALF_T;
        s9_g_d[j][c] = LW'(TW'(s8_base_q[j][c]) + (x >>> F));
      end
    end
  end

  // Stage 10 product and final red-axis lerp, mode select and saturation.
  always_comb begin
    logic signed [TW-1:0] ef;
    logic signed [TW-1:0] x;
    logic [VB-1:0]        ch [3];
    ef = $signed(TW'(side_q[9].fr[0]));
    for (int c = 0; c < 3; c++) begin
      s10_r_d[c] = (TW'(s9_g_q[1][c]) - TW'(s9_g_q[0][c])) * ef;
      x = TW'(s10_base_q[c]) + ((s10_r_q[c] + HALF_T) >>> F);
      ch[c] = (mode_q == l3d_pkg::MODE_TETRAHEDRAL) ? t_q[10][c] : sat_f(SW'(x));
    end
    fin.r    = ch[0];
    fin.g    = ch[1];
    fin.b    = ch[2];
    fin.a    = side_q[10].alpha;
    fin.last = side_q[10].last;
  end

  // Valid bits; a load leaves the pixel pipeline after stage 1 and travels
  // on its own valid bits up to the table write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      ld_v_q <= '0;
    end else if (en) begin
      v_q[1]    <= pix_i.valid;
      v_q[2]    <= v_q[1] && (s1_func_q == l3d_pkg::FUNC_PIXEL);
      v_q[10:3] <= v_q[9:2];
      ld_v_q[2] <= v_q[1] && (s1_func_q == l3d_pkg::FUNC_LOAD) &&
                   (32'(s1_idx_q) < DEPTH);
      ld_v_q[4:3] <= ld_v_q[3:2];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_func_q   <= pix_i.func;
      s1_idx_q    <= pix_i.entry_index;
      s1_entry_q  <= {pix_i.entry_b, pix_i.entry_g, pix_i.entry_r};
      s1_pix_q[0] <= pix_i.pix_r;
      s1_pix_q[1] <= pix_i.pix_g;
      s1_pix_q[2] <= pix_i.pix_b;
      s1_pix_q[3] <= pix_i.pix_a;
      s1_last_q   <= pix_i.in_last;

      ld_addr_q[2] <= AW'(s1_idx_q);
      ld_data_q[2] <= s1_entry_q;
      for (int s = 3; s <= 4; s++) begin
        ld_addr_q[s] <= ld_addr_q[s-1];
        ld_data_q[s] <= ld_data_q[s-1];
      end

      s2_g_q    <= s2_g_d;
      s2_a_q    <= s2_a_d;
      s2_last_q <= s1_last_q;

      s3_lo_q   <= s3_lo_d;
      s3_hi_q   <= s3_hi_d;
      side_q[3] <= side3_d;
      for (int s = 4; s <= 10; s++) begin
        side_q[s] <= side_q[s-1];
      end

      s4_rl_q <= (3*DW)'(s3_lo_q[0]) * (3*DW)'(d2_q);
      s4_rh_q <= (3*DW)'(s3_hi_q[0]) * (3*DW)'(d2_q);
      s4_gl_q <= (2*DW)'(s3_lo_q[1]) * (2*DW)'(d_q);
      s4_gh_q <= (2*DW)'(s3_hi_q[1]) * (2*DW)'(d_q);
      s4_bl_q <= s3_lo_q[2];
      s4_bh_q <= s3_hi_q[2];
      s4_n1_q <= s4_n1_d;
      s4_n2_q <= s4_n2_d;
      s4_tf_q <= s4_tf_d;

      s5_n1_q <= s4_n1_q;
      s5_n2_q <= s4_n2_q;
      s5_tf_q <= s4_tf_q;

      s6_p_q    <= s6_p_d;
      s6_base_q <= s6_base_d;
      s6_t_q    <= s6_t_d;
      s6_v0_q   <= s6_v0_d;

      s7_b_q <= s7_b_d;
      t_q[7] <= t7_d;
      for (int s = 8; s <= 10; s++) begin
        t_q[s] <= t_q[s-1];
      end

      s8_q_q <= s8_q_d;
      for (int j = 0; j < 2; j++) begin
        s8_base_q[j] <= s7_b_q[2*j];
      end

      s9_g_q <= s9_g_d;

      s10_r_q    <= s10_r_d;
      s10_base_q <= s9_g_q[0];
    end
  end

  // Output register with one spare slot behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (res_o.ready || !out_v_q) begin
      out_v_q  <= skid_v_q || v_q[10];
      skid_v_q <= 1'b0;
    end else if (en && v_q[10]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_o.ready || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : fin;
    end else if (en) begin
      skid_q <= fin;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.out_r    = $signed(out_q.r);
  assign res_o.out_g    = $signed(out_q.g);
  assign res_o.out_b    = $signed(out_q.b);
  assign res_o.out_a    = $signed(out_q.a);
  assign res_o.out_last = out_q.last;

  // The spare slot only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("spare output slot holds a result while the output is empty");

  // A load never creates a pixel in the pipeline.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[1] && (s1_func_q == l3d_pkg::FUNC_LOAD)) |=> !v_q[2])
    else $error("load item entered the pixel pipeline");

  // Cell corners stay inside the grid in use.
  a_corner_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (s3_hi_q[0] < d_q) && (s3_hi_q[1] < d_q) && (s3_hi_q[2] < d_q) &&
               (s3_lo_q[0] <= s3_hi_q[0]) && (s3_lo_q[1] <= s3_hi_q[1]) &&
               (s3_lo_q[2] <= s3_hi_q[2]))
    else $error("cell corner outside the grid");

  // A stall freezes the valid bits.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during a stall");

endmodule

// ===== dv/lut3d_color_interpolator_tb.sv =====
`timescale 1ns / 1ps

module lut3d_color_interpolator_tb;

  localparam int unsigned MAX_DIM    = 33;
  localparam int unsigned VALUE_BITS = 20;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned LUT_DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam longint      VAL_MAX    = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
  localparam longint      VAL_MIN    = -VAL_MAX - 1;
  localparam longint      HALF_LSB   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned START_DIM  = 5;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  typedef struct {
    logic                         func;
    logic [l3d_pkg::INDEX_W-1:0]  entry_index;
    val_t                         entry_r, entry_g, entry_b;
    val_t                         pix_r, pix_g, pix_b, pix_a;
    logic                         in_last;
  } lut_item_t;

  typedef struct {
    val_t r, g, b, a;
    logic last;
  } pixel_out_t;

  logic clk_i;
  logic rst_ni;

  l3d_pix_if #(.VALUE_BITS(VALUE_BITS)) pix_if ();
  l3d_res_if #(.VALUE_BITS(VALUE_BITS)) res_if ();
  l3d_cfg_if cfg_if ();

  lut3d_color_interpolator #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the table and the registers.
  longint      lut_mem [LUT_DEPTH][3];
  logic        mode_q;
  logic [5:0]  dim_q;
  logic [31:0] step_q;
  logic [31:0] alpha_q;

  lut_item_t   item_q[$];
  pixel_out_t  pixel_q[$];
  lut_item_t   cur_item;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic longint sat_val(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + (((b - a) * f + HALF_LSB) >>> FRAC_BITS);
  endfunction

  function automatic int unsigned dim_in_use();
    if (dim_q < 2) return 2;
    if (dim_q > MAX_DIM) return MAX_DIM;
    return dim_q;
  endfunction

  function automatic int unsigned cell_index(int unsigned d, int unsigned i0,
                                             int unsigned i1, int unsigned i2);
    int unsigned lin;
    lin = (i0 * d + i1) * d + i2;
    return (lin >= LUT_DEPTH) ? 0 : lin;
  endfunction

  // Applies a transferred load to the shadow table or queues a pixel's expected result.
  function automatic void interpolate_item(lut_item_t it);
    int unsigned d, lin;
    int unsigned lo[3], hi[3], id[3], ord[3];
    longint      fr[3], res[3], p[3], v[8][3], acc, b0, b1, b2, b3, g0, g1;
    longint unsigned g, maxfix;
    logic        c0, c1, c2;
    pixel_out_t  po;
    if (it.func == l3d_pkg::FUNC_LOAD) begin
      if (it.entry_index < LUT_DEPTH) begin
        lut_mem[it.entry_index][0] = it.entry_r;
        lut_mem[it.entry_index][1] = it.entry_g;
        lut_mem[it.entry_index][2] = it.entry_b;
      end
      return;
    end
    d = dim_in_use();
    maxfix = longint'(d - 1) << FRAC_BITS;
    p[0] = it.pix_r;
    p[1] = it.pix_g;
    p[2] = it.pix_b;
    for (int c = 0; c < 3; c++) begin
      g = 0;
      if (p[c] > 0) g = (longint'(p[c]) * longint'({32'd0, step_q})) >> 16;
      if (g > maxfix) g = maxfix;
      lo[c] = g >> FRAC_BITS;
      fr[c] = g & ((64'd1 << FRAC_BITS) - 1);
      hi[c] = (lo[c] < d - 1) ? lo[c] + 1 : lo[c];
    end
    if (mode_q == l3d_pkg::MODE_TRILINEAR) begin
      for (int n = 0; n < 8; n++) begin
        lin = cell_index(d, n[2] ? hi[0] : lo[0], n[1] ? hi[1] : lo[1],
                         n[0] ? hi[2] : lo[2]);
        for (int c = 0; c < 3; c++) v[n][c] = lut_mem[lin][c];
      end
      for (int c = 0; c < 3; c++) begin
        b0 = blend(v[0][c], v[1][c], fr[2]);
        b1 = blend(v[2][c], v[3][c], fr[2]);
        b2 = blend(v[4][c], v[5][c], fr[2]);
        b3 = blend(v[6][c], v[7][c], fr[2]);
        g0 = blend(b0, b1, fr[1]);
        g1 = blend(b2, b3, fr[1]);
        res[c] = blend(g0, g1, fr[0]);
      end
    end else begin
      // Pick the tetrahedron from the order of the fractions.
      c0 = fr[0] >= fr[1];
      c1 = fr[1] >= fr[2];
      c2 = fr[2] >= fr[0];
      if (c0) begin
        if (c1)       ord = '{0, 1, 2};
        else if (!c2) ord = '{0, 2, 1};
        else          ord = '{2, 0, 1};
      end else begin
        if (!c1)      ord = '{2, 1, 0};
        else if (!c2) ord = '{1, 0, 2};
        else          ord = '{1, 2, 0};
      end
      id = lo;
      for (int k = 0; k < 4; k++) begin
        if (k > 0) id[ord[k-1]] = hi[ord[k-1]];
        lin = cell_index(d, id[0], id[1], id[2]);
        for (int c = 0; c < 3; c++) v[k][c] = lut_mem[lin][c];
      end
      for (int c = 0; c < 3; c++) begin
        acc = fr[ord[0]] * (v[1][c] - v[0][c]) + fr[ord[1]] * (v[2][c] - v[1][c])
            + fr[ord[2]] * (v[3][c] - v[2][c]);
        res[c] = v[0][c] + ((acc + HALF_LSB) >>> FRAC_BITS);
      end
    end
    po.r = val_t'(sat_val(res[0]));
    po.g = val_t'(sat_val(res[1]));
    po.b = val_t'(sat_val(res[2]));
    po.a = val_t'(sat_val((longint'(it.pix_a) * longint'({32'd0, alpha_q}) + 32768)
                          >>> 16));
    po.last = it.in_last;
    pixel_q.push_back(po);
  endfunction

  // Input driver: one transfer per item, random gaps with idle-free bursts.
  int unsigned in_gap;
  logic        in_burst;

  always @(posedge clk_i or negedge rst_ni) begin
    logic vld;
    if (!rst_ni) begin
      pix_if.valid       <= 1'b0;
      pix_if.func        <= l3d_pkg::FUNC_LOAD;
      pix_if.entry_index <= '0;
      pix_if.entry_r     <= '0;
      pix_if.entry_g     <= '0;
      pix_if.entry_b     <= '0;
      pix_if.pix_r       <= '0;
      pix_if.pix_g       <= '0;
      pix_if.pix_b       <= '0;
      pix_if.pix_a       <= '0;
      pix_if.in_last     <= 1'b0;
      in_gap   = 0;
      in_burst = 1'b0;
    end else begin
      vld = pix_if.valid;
      if (pix_if.valid && pix_if.ready) begin
        interpolate_item(cur_item);
        if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
        vld = 1'b0;
      end
      if (!vld) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          pix_if.func        <= cur_item.func;
          pix_if.entry_index <= cur_item.entry_index;
          pix_if.entry_r     <= cur_item.entry_r;
          pix_if.entry_g     <= cur_item.entry_g;
          pix_if.entry_b     <= cur_item.entry_b;
          pix_if.pix_r       <= cur_item.pix_r;
          pix_if.pix_g       <= cur_item.pix_g;
          pix_if.pix_b       <= cur_item.pix_b;
          pix_if.pix_a       <= cur_item.pix_a;
          pix_if.in_last     <= cur_item.in_last;
          vld = 1'b1;
        end
      end
      pix_if.valid <= vld;
    end
  end

  // Output monitor: stalls the result channel and checks every transfer.
  int unsigned out_stall;
  logic        out_burst;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t ex;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      out_stall = 0;
      out_burst = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected result transfer");
          fail_cnt++;
        end else begin
          ex = pixel_q.pop_front();
          if (res_if.out_r !== ex.r) begin
            $error("out_r expected %0d actual %0d", ex.r, res_if.out_r);
            fail_cnt++;
          end
          if (res_if.out_g !== ex.g) begin
            $error("out_g expected %0d actual %0d", ex.g, res_if.out_g);
            fail_cnt++;
          end
          if (res_if.out_b !== ex.b) begin
            $error("out_b expected %0d actual %0d", ex.b, res_if.out_b);
            fail_cnt++;
          end
          if (res_if.out_a !== ex.a) begin
            $error("out_a expected %0d actual %0d", ex.a, res_if.out_a);
            fail_cnt++;
          end
          if (res_if.out_last !== ex.last) begin
            $error("out_last expected %0b actual %0b", ex.last, res_if.out_last);
            fail_cnt++;
          end
        end
        if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 4);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      res_if.ready <= (out_stall == 0);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Register write while the block is idle.
  task automatic write_reg(l3d_pkg::reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      l3d_pkg::REG_INTERP_MODE: mode_q  = value[0];
      l3d_pkg::REG_LUT_DIM:     dim_q   = value[5:0];
      l3d_pkg::REG_STEP_SCALE:  step_q  = value;
      default:                  alpha_q = value;
    endcase
  endtask

  task automatic wait_idle();
    wait (item_q.size() == 0 && !pix_if.valid && pixel_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic val_t rand_val();
    return val_t'($urandom());
  endfunction

  function automatic void push_load(int unsigned idx);
    lut_item_t it;
    it.func        = l3d_pkg::FUNC_LOAD;
    it.entry_index = idx;
    it.entry_r     = rand_val();
    it.entry_g     = rand_val();
    it.entry_b     = rand_val();
    it.pix_r       = rand_val();
    it.pix_g       = rand_val();
    it.pix_b       = rand_val();
    it.pix_a       = rand_val();
    it.in_last     = $urandom_range(0, 1);
    item_q.push_back(it);
  endfunction

  function automatic void push_pixel(val_t r, val_t g, val_t b, val_t a);
    lut_item_t it;
    it.func        = l3d_pkg::FUNC_PIXEL;
    it.entry_index = $urandom();
    it.entry_r     = rand_val();
    it.entry_g     = rand_val();
    it.entry_b     = rand_val();
    it.pix_r       = r;
    it.pix_g       = g;
    it.pix_b       = b;
    it.pix_a       = a;
    it.in_last     = $urandom_range(0, 1);
    item_q.push_back(it);
  endfunction

  // Color component: full range, inside [0, 1.0], or an extreme.
  function automatic val_t rand_color();
    case ($urandom_range(0, 3))
      0: return rand_val();
      1, 2: return val_t'($urandom_range(0, 65536));
      default: begin
        case ($urandom_range(0, 5))
          0: return val_t'(VAL_MAX);
          1: return val_t'(VAL_MIN);
          2: return '0;
          3: return val_t'(-1);
          4: return val_t'(1);
          default: return val_t'(65536);
        endcase
      end
    endcase
  endfunction

  // Random pixels with loads mixed in; some channels share a value to tie fractions.
  task automatic random_phase(int unsigned n_pix);
    int unsigned d;
    val_t r, g, b;
    d = dim_in_use();
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 6) == 0) push_load($urandom_range(0, d * d * d - 1));
      if ($urandom_range(0, 40) == 0) push_load($urandom_range(LUT_DEPTH, 65535));
      r = rand_color();
      g = ($urandom_range(0, 4) == 0) ? r : rand_color();
      b = ($urandom_range(0, 4) == 0) ? g : rand_color();
      push_pixel(r, g, b, rand_val());
    end
    wait_idle();
  endtask

  initial begin
    int unsigned d;
    logic [5:0]  dims[8];
    cfg_if.valid  = 1'b0;
    cfg_if.index  = l3d_pkg::REG_INTERP_MODE;
    cfg_if.data   = '0;
    mode_q  = l3d_pkg::MODE_TRILINEAR;
    dim_q   = l3d_pkg::RST_LUT_DIM;
    step_q  = l3d_pkg::RST_STEP_SCALE;
    alpha_q = l3d_pkg::RST_ALPHA_SCALE;
    wait (rst_ni === 1'b1);

    // Use a small grid so that filling every entry in use stays short.
    write_reg(l3d_pkg::REG_LUT_DIM, START_DIM);
    for (int i = 0; i < START_DIM * START_DIM * START_DIM; i++) push_load(i);
    // Loads past the table are dropped.
    push_load(LUT_DEPTH);
    push_load(65535);
    // Directed pixels: extremes, ties, grid points and the top corner.
    push_pixel(val_t'(VAL_MAX), val_t'(VAL_MAX), val_t'(VAL_MAX), val_t'(VAL_MAX));
    push_pixel(val_t'(VAL_MIN), val_t'(VAL_MIN), val_t'(VAL_MIN), val_t'(VAL_MIN));
    push_pixel('0, '0, '0, '0);
    push_pixel(val_t'(-1), val_t'(1), val_t'(65536), val_t'(-1));
    push_pixel(val_t'(2048), val_t'(2048), val_t'(2048), val_t'(65536));
    push_pixel(val_t'(2047), val_t'(2049), val_t'(1000), val_t'(12345));
    push_pixel(val_t'(1000), val_t'(2049), val_t'(2047), val_t'(-12345));
    push_pixel(val_t'(2049), val_t'(1000), val_t'(2047), val_t'(32768));
    push_pixel(val_t'(63488), val_t'(63487), val_t'(63489), val_t'(1));
    push_pixel(val_t'(65535), val_t'(64512), val_t'(0), val_t'(-32768));
    wait_idle();
    random_phase(80);

    // Tetrahedral with the largest scales, so that large channel values clamp.
    write_reg(l3d_pkg::REG_INTERP_MODE, l3d_pkg::MODE_TETRAHEDRAL);
    write_reg(l3d_pkg::REG_STEP_SCALE, 32'hFFFF_FFFF);
    write_reg(l3d_pkg::REG_ALPHA_SCALE, 32'hFFFF_FFFF);
    random_phase(40);
    write_reg(l3d_pkg::REG_STEP_SCALE, 32'd2097152);
    write_reg(l3d_pkg::REG_ALPHA_SCALE, 32'd65536);
    random_phase(80);

    // Further settings, out-of-range dimensions among them.
    dims = '{6'd1, 6'd0, 6'd3, 6'd4, 6'd63, 6'd2, 6'd5, 6'd34};
    for (int p = 0; p < 8; p++) begin
      write_reg(l3d_pkg::REG_INTERP_MODE, p[0]);
      write_reg(l3d_pkg::REG_LUT_DIM, dims[p]);
      d = dim_in_use();
      case ($urandom_range(0, 3))
        0: write_reg(l3d_pkg::REG_STEP_SCALE, (d - 1) << 16);
        1: write_reg(l3d_pkg::REG_STEP_SCALE, $urandom());
        2: write_reg(l3d_pkg::REG_STEP_SCALE, (p == 2) ? 32'd0 : ((d - 1) << 17));
        default: write_reg(l3d_pkg::REG_STEP_SCALE, $urandom_range(0, (d - 1) << 18));
      endcase
      case ($urandom_range(0, 2))
        0: write_reg(l3d_pkg::REG_ALPHA_SCALE, (p == 5) ? 32'd0 : 32'd65536);
        1: write_reg(l3d_pkg::REG_ALPHA_SCALE, $urandom_range(0, 32'h0004_0000));
        default: write_reg(l3d_pkg::REG_ALPHA_SCALE, $urandom());
      endcase
      if (d == MAX_DIM) begin
        // Keep every coordinate below 1.0 so only the first cell is read.
        write_reg(l3d_pkg::REG_STEP_SCALE, $urandom_range(0, 8192));
        for (int i = 0; i < 8; i++) begin
          push_load((i[2] * MAX_DIM + i[1]) * MAX_DIM + i[0]);
        end
      end else begin
        for (int i = 0; i < d * d * d; i++) push_load(i);
      end
      random_phase(100);
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
